// ===== src/msq_pkg.sv =====
// Shared types, constants and the quarter-step pattern table for the
// multi-stepper sequencer. No dependencies.
`default_nettype none

package msq_pkg;

    // Motors served by one block (1 to 8).
    localparam int NUM_MOTORS = 8;
    localparam int MOTOR_AW   = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    localparam int CMD_W     = 1;
    localparam int INDEX_W   = 3;
    localparam int STEPS_W   = 16;
    localparam int PHASE_W   = 4;
    localparam int PATTERN_W = 6;
    localparam int WORD_W    = 48;

    localparam logic [CMD_W-1:0] CMD_TICK = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SET  = 1'b1;

    localparam logic [PATTERN_W-1:0] DISABLE_PATTERN = 6'h3f;

    typedef logic [MOTOR_AW-1:0] t_motor_idx;

    typedef struct packed {
        logic signed [STEPS_W-1:0] steps;
        logic [PHASE_W-1:0]        phase;
    } t_entry;

    // Result of one motor update: its pattern and the entry to write back.
    typedef struct packed {
        logic [PATTERN_W-1:0] pattern;
        t_entry               entry;
    } t_step_res;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    function automatic logic [PATTERN_W-1:0] step_pattern(input logic [PHASE_W-1:0] sel);
        logic [PATTERN_W-1:0] pat;
        case (sel)
            4'h0: pat = 6'h0f;
            4'h1: pat = 6'h0b;
            4'h2: pat = 6'h2d;
            4'h3: pat = 6'h19;
            4'h4: pat = 6'h31;
            4'h5: pat = 6'h11;
            4'h6: pat = 6'h25;
            4'h7: pat = 6'h03;
            4'h8: pat = 6'h06;
            4'h9: pat = 6'h02;
            4'ha: pat = 6'h24;
            4'hb: pat = 6'h10;
            4'hc: pat = 6'h38;
            4'hd: pat = 6'h18;
            4'he: pat = 6'h2c;
            default: pat = 6'h0a;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ===== src/msq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module msq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/msq_motor_step.sv =====
// Per-motor update: picks the quarter-step pattern and advances phase/count.
// Depends on msq_pkg.
`default_nettype none

module msq_motor_step (
    input  wire msq_pkg::t_entry i_entry,
    output msq_pkg::t_step_res   o_res
);

    logic                         moving;
    logic                         fwd;
    logic [msq_pkg::PHASE_W-1:0]  sel;
    logic [msq_pkg::PHASE_W-1:0]  phase_nxt;
    logic signed [msq_pkg::STEPS_W-1:0] steps_nxt;

    always_comb begin
        moving    = (i_entry.steps != '0);
        fwd       = !i_entry.steps[msq_pkg::STEPS_W-1];
        sel       = fwd ? i_entry.phase : ~i_entry.phase;
        phase_nxt = i_entry.phase + 1'b1;
        // count moves toward zero only when the phase wraps
        if (phase_nxt == '0) begin
            steps_nxt = fwd ? (i_entry.steps - 16'sd1) : (i_entry.steps + 16'sd1);
        end else begin
            steps_nxt = i_entry.steps;
        end

        if (moving) begin
            o_res.pattern     = msq_pkg::step_pattern(sel);
            o_res.entry.steps = steps_nxt;
            o_res.entry.phase = phase_nxt;
        end else begin
            o_res.pattern = msq_pkg::DISABLE_PATTERN;
            o_res.entry   = i_entry;
        end
    end

endmodule

`default_nettype wire

// ===== src/multi_stepper_quarter_step_sequencer_core.sv =====
// Top level of the multi-stepper quarter-step sequencer.
// Depends on msq_pkg, msq_ram and msq_motor_step.
`default_nettype none

// Usage
//   Input channel (i_in_valid / o_in_stall) carries requests of two kinds:
//   a set request (i_command = set) loads one motor's signed step count and
//   leaves its phase; an index at or beyond the motor count is dropped.
//   A tick request walks all motors and yields one 48-bit drive word on the
//   output channel (o_out_valid / i_out_stall), first motor in the top bits.
//   Timing
//   A set request gives no result. A tick request keeps the input stalled
//   while it runs: counts and phases sit in two RAMs and are read, updated
//   and written back one motor per cycle, then the done state places the
//   word in the output register once that register is free.
//   Stalling
//   The output register holds a finished word while the receiver stalls;
//   new requests are still taken meanwhile. A following tick waits in its
//   final cycle until the output register is free.
//   Reset
//   Per-motor valid flags for counts and phases are cleared, so every motor
//   reads as count zero, phase zero (idle, disable pattern) until written.

module multi_stepper_quarter_step_sequencer_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [msq_pkg::CMD_W-1:0]           i_command,
    input  wire logic [msq_pkg::INDEX_W-1:0]         i_motor_index,
    input  wire logic signed [msq_pkg::STEPS_W-1:0]  i_motion_value,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [msq_pkg::WORD_W-1:0]               o_drive_word
);

    localparam msq_pkg::t_motor_idx LAST_IDX = msq_pkg::t_motor_idx'(msq_pkg::NUM_MOTORS - 1);

    msq_pkg::t_state r_state, n_state;
    msq_pkg::t_motor_idx r_idx, n_idx;
    logic [msq_pkg::NUM_MOTORS-1:0] r_stp_vld, n_stp_vld;
    logic [msq_pkg::NUM_MOTORS-1:0] r_ph_vld, n_ph_vld;
    logic r_stp_rd_vld;
    logic r_ph_rd_vld;
    logic [msq_pkg::WORD_W-1:0] r_word, n_word;
    logic r_out_valid, n_out_valid;
    logic [msq_pkg::WORD_W-1:0] r_drive, n_drive;

    logic in_acc;
    logic set_acc;
    logic set_ok;
    logic tick_acc;
    logic out_free;

    logic                            steps_we;
    logic                            phase_we;
    msq_pkg::t_motor_idx             ram_waddr;
    logic [msq_pkg::STEPS_W-1:0]     steps_wdata;
    logic [msq_pkg::PHASE_W-1:0]     phase_wdata;
    logic                            ram_re;
    msq_pkg::t_motor_idx             ram_raddr;
    logic [msq_pkg::STEPS_W-1:0]     steps_rdata;
    logic [msq_pkg::PHASE_W-1:0]     phase_rdata;

    msq_pkg::t_entry   cur_entry;
    msq_pkg::t_step_res step_res;

    assign o_in_stall  = (r_state != msq_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_drive_word = r_drive;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign set_acc  = in_acc && (i_command == msq_pkg::CMD_SET);
    assign tick_acc = in_acc && (i_command == msq_pkg::CMD_TICK);
    assign set_ok   = (32'(i_motor_index) < msq_pkg::NUM_MOTORS);
    assign out_free = !r_out_valid || !i_out_stall;

    // never-written entries read as the reset value (idle, phase zero)
    always_comb begin
        cur_entry.steps = r_stp_rd_vld ? steps_rdata : '0;
        cur_entry.phase = r_ph_rd_vld ? phase_rdata : '0;
    end

    msq_motor_step u_step (
        .i_entry (cur_entry),
        .o_res   (step_res)
    );

    msq_ram #(
        .WIDTH (msq_pkg::STEPS_W),
        .DEPTH (msq_pkg::NUM_MOTORS)
    ) u_steps_ram (
        .i_clk   (i_clk),
        .i_we    (steps_we),
        .i_waddr (ram_waddr),
        .i_wdata (steps_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (steps_rdata)
    );

    msq_ram #(
        .WIDTH (msq_pkg::PHASE_W),
        .DEPTH (msq_pkg::NUM_MOTORS)
    ) u_phase_ram (
        .i_clk   (i_clk),
        .i_we    (phase_we),
        .i_waddr (ram_waddr),
        .i_wdata (phase_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (phase_rdata)
    );

    assign phase_wdata = step_res.entry.phase;

    // RAM ports: set writes happen only in idle, updates only while running,
    // so the write port never sees both. The read of motor k+1 overlaps the
    // write-back of motor k, which is a different entry.
    always_comb begin
        steps_we    = 1'b0;
        phase_we    = 1'b0;
        ram_waddr   = r_idx;
        steps_wdata = step_res.entry.steps;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        if (r_state == msq_pkg::S_RUN) begin
            steps_we = 1'b1;
            phase_we = 1'b1;
            if (r_idx != LAST_IDX) begin
                ram_re    = 1'b1;
                ram_raddr = r_idx + 1'b1;
            end
        end else if (set_acc && set_ok) begin
            // a set rewrites the count only; the phase entry is left alone
            steps_we    = 1'b1;
            ram_waddr   = msq_pkg::t_motor_idx'(i_motor_index);
            steps_wdata = i_motion_value;
        end
        if (tick_acc) begin
            ram_re    = 1'b1;
            ram_raddr = '0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_stp_vld   = r_stp_vld;
        n_ph_vld    = r_ph_vld;
        n_word      = r_word;
        n_out_valid = r_out_valid;
        n_drive     = r_drive;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            msq_pkg::S_IDLE: begin
                if (set_acc && set_ok) begin
                    n_stp_vld[msq_pkg::t_motor_idx'(i_motor_index)] = 1'b1;
                end
                if (tick_acc) begin
                    n_state = msq_pkg::S_RUN;
                    n_idx   = '0;
                    n_word  = '0;
                end
            end
            msq_pkg::S_RUN: begin
                n_stp_vld[r_idx] = 1'b1;
                n_ph_vld[r_idx]  = 1'b1;
                n_word = {r_word[msq_pkg::WORD_W-msq_pkg::PATTERN_W-1:0], step_res.pattern};
                if (r_idx == LAST_IDX) begin
                    n_state = msq_pkg::S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            msq_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_drive     = r_word;
                    n_state     = msq_pkg::S_IDLE;
                end
            end
            default: n_state = msq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= msq_pkg::S_IDLE;
            r_idx        <= '0;
            r_stp_vld    <= '0;
            r_ph_vld     <= '0;
            r_out_valid  <= 1'b0;
            r_stp_rd_vld <= 1'b0;
            r_ph_rd_vld  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_stp_vld   <= n_stp_vld;
            r_ph_vld    <= n_ph_vld;
            r_out_valid <= n_out_valid;
            if (ram_re) begin
                r_stp_rd_vld <= r_stp_vld[ram_raddr];
                r_ph_rd_vld  <= r_ph_vld[ram_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_drive <= n_drive;
    end

endmodule

`default_nettype wire

// ===== dv/multi_stepper_quarter_step_sequencer_core_tb.sv =====
// Self-checking testbench for multi_stepper_quarter_step_sequencer_core: a directed table,
// then random set/tick bursts with random idling on both sides.
// Depends on msq_pkg and the RTL of the sequencer core.
`timescale 1ns / 100ps

module multi_stepper_quarter_step_sequencer_core_tb;

    localparam int RAND_ITEMS     = 725;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int TAIL_CYCLES    = msq_pkg::NUM_MOTORS + 4;

    // Quarter-step patterns, entry 0 in the low bits.
    localparam logic [16*msq_pkg::PATTERN_W-1:0] QSTEP_TABLE = {
        6'h0a, 6'h2c, 6'h18, 6'h38, 6'h10, 6'h24, 6'h02, 6'h06,
        6'h03, 6'h25, 6'h11, 6'h31, 6'h19, 6'h2d, 6'h0b, 6'h0f
    };

    // One directed request; word is used only where typed is set.
    typedef struct packed {
        logic [msq_pkg::CMD_W-1:0]          cmd;
        logic [msq_pkg::INDEX_W-1:0]        idx;
        logic signed [msq_pkg::STEPS_W-1:0] val;
        logic                               typed;
        logic [msq_pkg::WORD_W-1:0]         word;
    } t_stim_row;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_in_valid = 1'b0;
    logic [msq_pkg::CMD_W-1:0]            i_command = msq_pkg::CMD_TICK;
    logic [msq_pkg::INDEX_W-1:0]          i_motor_index = '0;
    logic signed [msq_pkg::STEPS_W-1:0]   i_motion_value = '0;
    logic                                 i_out_stall = 1'b0;
    logic                                 o_in_stall;
    logic                                 o_out_valid;
    logic [msq_pkg::WORD_W-1:0]           o_drive_word;

    // Predicted motor state, kept in step with accepted requests.
    logic signed [msq_pkg::STEPS_W-1:0]   motor_steps [msq_pkg::NUM_MOTORS];
    logic [msq_pkg::PHASE_W-1:0]          motor_phase [msq_pkg::NUM_MOTORS];

    logic [msq_pkg::WORD_W-1:0]           drive_word_q [$];
    t_stim_row                            stim_tbl [$];
    int                                   mismatch_cnt = 0;
    int                                   cycle_cnt = 0;
    bit                                   rx_hold_req = 1'b0;

    multi_stepper_quarter_step_sequencer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_motor_index  (i_motor_index),
        .i_motion_value (i_motion_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_drive_word   (o_drive_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void clear_motors();
        for (int i = 0; i < msq_pkg::NUM_MOTORS; i++) begin
            motor_steps[i] = '0;
            motor_phase[i] = '0;
        end
    endfunction

    // Set request: new count, phase untouched; out-of-range index dropped.
    function automatic void load_motor_steps(input logic [msq_pkg::INDEX_W-1:0] idx,
                                             input logic signed [msq_pkg::STEPS_W-1:0] val);
        if (int'(idx) < msq_pkg::NUM_MOTORS) begin
            motor_steps[idx] = val;
        end
    endfunction

    // Tick request: walk motors first to last, first motor ends up on top.
    // Bits shifted past WORD_W simply fall off.
    function automatic logic [msq_pkg::WORD_W-1:0] advance_motors();
        logic [msq_pkg::WORD_W-1:0]    word;
        logic [msq_pkg::PHASE_W-1:0]   sel;
        logic [msq_pkg::PATTERN_W-1:0] pat;
        word = '0;
        for (int i = 0; i < msq_pkg::NUM_MOTORS; i++) begin
            if (motor_steps[i] != 0) begin
                // backward runs the table from the far end
                sel = (motor_steps[i] > 0) ? motor_phase[i] : ~motor_phase[i];
                pat = QSTEP_TABLE[sel*msq_pkg::PATTERN_W +: msq_pkg::PATTERN_W];
                motor_phase[i] = motor_phase[i] + 4'd1;
                if (motor_phase[i] == '0) begin
                    // a whole step done: one closer to zero (-32768 included)
                    motor_steps[i] = (motor_steps[i] > 0) ? motor_steps[i] - 16'sd1
                                                          : motor_steps[i] + 16'sd1;
                end
            end else begin
                pat = msq_pkg::DISABLE_PATTERN;
            end
            word = (word << msq_pkg::PATTERN_W)
                 | {{(msq_pkg::WORD_W-msq_pkg::PATTERN_W){1'b0}}, pat};
        end
        return word;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic t_stim_row stim_row(input logic [msq_pkg::CMD_W-1:0] cmd,
                                           input int motor, input int steps,
                                           input logic typed,
                                           input logic [msq_pkg::WORD_W-1:0] word);
        t_stim_row r;
        r.cmd   = cmd;
        r.idx   = motor[msq_pkg::INDEX_W-1:0];
        r.val   = steps[msq_pkg::STEPS_W-1:0];
        r.typed = typed;
        r.word  = word;
        return r;
    endfunction

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request, hold it until taken, update the prediction,
    // then maybe idle. With no idle the next call re-drives valid in
    // this same step, so valid is never dropped and raised in one step.
    task automatic send_req(input logic [msq_pkg::CMD_W-1:0] cmd,
                            input logic [msq_pkg::INDEX_W-1:0] idx,
                            input logic signed [msq_pkg::STEPS_W-1:0] val,
                            input logic typed,
                            input logic [msq_pkg::WORD_W-1:0] typed_word);
        logic [msq_pkg::WORD_W-1:0] pred;
        int                         gap;
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_motor_index  <= idx;
        i_motion_value <= val;
        do @(posedge i_clk); while (o_in_stall);
        if (cmd == msq_pkg::CMD_TICK) begin
            pred = advance_motors();
            drive_word_q.push_back(typed ? typed_word : pred);
        end else begin
            load_motor_steps(idx, val);
        end
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sender stands aside until every word owed has come out.
    task automatic drain_words();
        i_in_valid <= 1'b0;
        while (drive_word_q.size() != 0) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------
    initial begin : tx_side
        logic [msq_pkg::INDEX_W-1:0]        idx;
        logic signed [msq_pkg::STEPS_W-1:0] val;
        logic [31:0]                        raw;
        int                                 r;
        int                                 n_set;
        int                                 n_tick;
        int                                 rand_cnt;
        bit                                 drained;

        clear_motors();

        // After reset every motor is idle: all fields disable.
        stim_tbl.push_back(stim_row(msq_pkg::CMD_TICK, 0, 0, 1'b1, 48'hffff_ffff_ffff));
        stim_tbl.push_back(stim_row(msq_pkg::CMD_SET,  0, 1,      1'b0, '0));
        stim_tbl.push_back(stim_row(msq_pkg::CMD_SET,  7, -1,     1'b0, '0));
        stim_tbl.push_back(stim_row(msq_pkg::CMD_SET,  3, 32767,  1'b0, '0));
        stim_tbl.push_back(stim_row(msq_pkg::CMD_SET,  4, -32768, 1'b0, '0));
        stim_tbl.push_back(stim_row(msq_pkg::CMD_SET,  5, 0,      1'b0, '0));
        stim_tbl.push_back(stim_row(msq_pkg::CMD_TICK, 0, 0,      1'b0, '0));
        stim_tbl.push_back(stim_row(msq_pkg::CMD_TICK, 7, -1,     1'b0, '0));
        // reload a motor mid-step: phase must carry over
        stim_tbl.push_back(stim_row(msq_pkg::CMD_SET,  0, 2,      1'b0, '0));
        // stop a moving motor
        stim_tbl.push_back(stim_row(msq_pkg::CMD_SET,  7, 0,      1'b0, '0));
        stim_tbl.push_back(stim_row(msq_pkg::CMD_TICK, 5, 21845,  1'b0, '0));
        stim_tbl.push_back(stim_row(msq_pkg::CMD_SET,  1, -2,     1'b0, '0));
        stim_tbl.push_back(stim_row(msq_pkg::CMD_SET,  2, 21845,  1'b0, '0));
        stim_tbl.push_back(stim_row(msq_pkg::CMD_SET,  6, -21846, 1'b0, '0));
        for (int k = 0; k < 8; k++) begin
            stim_tbl.push_back(stim_row(msq_pkg::CMD_TICK, k, -21846, 1'b0, '0));
        end
        stim_tbl.push_back(stim_row(msq_pkg::CMD_SET,  3, 0,      1'b0, '0));
        stim_tbl.push_back(stim_row(msq_pkg::CMD_SET,  4, 0,      1'b0, '0));
        stim_tbl.push_back(stim_row(msq_pkg::CMD_TICK, 0, 0,      1'b0, '0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_tbl[k]) begin
            send_req(stim_tbl[k].cmd, stim_tbl[k].idx, stim_tbl[k].val,
                     stim_tbl[k].typed, stim_tbl[k].word);
        end

        // Receiver goes deaf for a while; keep pushing so the core backs up.
        rx_hold_req = 1'b1;

        // Random bursts: load a few motors, then tick long enough for
        // small counts to run down to zero. Tick fields carry junk.
        rand_cnt = 0;
        drained  = 1'b0;
        while (rand_cnt < RAND_ITEMS) begin
            n_set = $urandom_range(1, 4);
            repeat (n_set) begin
                raw = $urandom();
                idx = raw[msq_pkg::INDEX_W-1:0];
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    r   = $urandom_range(0, 8) - 4;
                    val = r[msq_pkg::STEPS_W-1:0];
                end else if (r < 80) begin
                    raw = $urandom();
                    val = raw[msq_pkg::STEPS_W-1:0];
                end else begin
                    case ($urandom_range(0, 4))
                        0:       val = 16'sh7fff;
                        1:       val = 16'sh8000;
                        2:       val = 16'sh0001;
                        3:       val = 16'shffff;
                        default: val = 16'sh0000;
                    endcase
                end
                send_req(msq_pkg::CMD_SET, idx, val, 1'b0, '0);
                rand_cnt++;
            end

            r = $urandom_range(0, 99);
            n_tick = (r < 5) ? 0 : (r < 75) ? $urandom_range(1, 20) : $urandom_range(20, 40);
            repeat (n_tick) begin
                raw = $urandom();
                idx = raw[msq_pkg::INDEX_W-1:0];
                val = raw[msq_pkg::STEPS_W+msq_pkg::INDEX_W-1:msq_pkg::INDEX_W];
                send_req(msq_pkg::CMD_TICK, idx, val, 1'b0, '0);
                rand_cnt++;
            end

            if (!drained && rand_cnt >= RAND_ITEMS / 2) begin
                drained = 1'b1;
                drain_words();
            end
        end

        drain_words();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver: random stall pattern, plus one long hold on request
    // ---------------------------------------------------------------
    initial begin : rx_side
        bit held;
        held = 1'b0;
        forever begin
            if (rx_hold_req && !held) begin
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else if ($urandom_range(0, 99) < 65) begin
                i_out_stall <= 1'b0;
                repeat (1 + pick_gap()) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                repeat (1 + pick_gap()) @(posedge i_clk);
            end
        end
    end

    // ---------------------------------------------------------------
    // Result check, oldest expectation first
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [msq_pkg::WORD_W-1:0] exp_word;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (drive_word_q.size() == 0) begin
                $error("drive_word: none expected, got %h", o_drive_word);
                mismatch_cnt++;
            end else begin
                exp_word = drive_word_q.pop_front();
                if (o_drive_word !== exp_word) begin
                    $error("drive_word: expected %h, got %h", exp_word, o_drive_word);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
